// File: src/dfr_pkg.sv
// Shared types and constants for the XOR-checked frame deframer.
package dfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 3;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = 1'b1;

    localparam logic [BYTE_W-1:0] HEADER_BYTE_RESET = 8'd60;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'd127;

    // Byte role codes carried in tuser
    localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OP      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TARGET  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LEN     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CHECK   = 3'd5;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_OP      = 3'd1,
        PH_TARGET  = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [BYTE_W-1:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic              frame_good;
        logic              frame_end;
        logic [KIND_W-1:0] byte_kind;
        logic [BYTE_W-1:0] data_byte;
    } result_t;

endpackage

// File: src/xor_checked_frame_deframer_core.sv
// Top level of the XOR-checked frame deframer.
// Takes one received byte per word on the slave stream, hunts for the header
// byte, then passes out header, operation, target, length, payload and
// checksum bytes tagged with their role. The checksum word carries tlast and
// a good flag when it equals the XOR of header through last payload byte; a
// length above max_payload ends the frame at the length word with tlast and
// no good flag. Other bytes seen while hunting are dropped. One byte is taken every
// cycle: the parser state is registered per accepted byte and results go into a
// two-entry output buffer, so input is held off only when both entries are
// full under downstream backpressure. No clearing pass after reset.
module xor_checked_frame_deframer_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // [7:0] rx_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,  // [7:0] data_byte
    output logic                               m_axis_tlast,  // frame_end
    output logic [3:0]                         m_axis_tuser,  // [2:0] byte_kind, [3] frame_good
    input  logic                               cfg_we,
    input  logic [dfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dfr_pkg::BYTE_W-1:0]         cfg_data
);
    import dfr_pkg::*;

    cfg_t    cfg;
    logic    in_accept;
    logic    res_valid;
    result_t res;
    result_t out_data;
    logic    can_push;

    assign s_axis_tready = can_push;
    assign in_accept     = s_axis_tvalid && can_push;

    dfr_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_byte   (s_axis_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    dfr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .can_push  (can_push),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = out_data.data_byte;
    assign m_axis_tlast = out_data.frame_end;
    assign m_axis_tuser = {out_data.frame_good, out_data.byte_kind};

endmodule

// File: src/dfr_regs.sv
// Configuration registers: header byte and payload length limit.
module dfr_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dfr_pkg::BYTE_W-1:0]          cfg_data,
    output dfr_pkg::cfg_t                       cfg
);
    import dfr_pkg::*;

    logic [BYTE_W-1:0] header_byte_reg;
    logic [BYTE_W-1:0] max_payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg <= HEADER_BYTE_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_BYTE: header_byte_reg <= cfg_data;
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg.header_byte = header_byte_reg;
    assign cfg.max_payload = max_payload_reg;

endmodule

// File: src/dfr_parser.sv
// Frame parser: phase, payload count and running XOR; tags each accepted byte.
module dfr_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dfr_pkg::cfg_t               cfg,
    input  logic                        in_accept,
    input  logic [dfr_pkg::BYTE_W-1:0]  in_byte,
    output logic                        res_valid,
    output dfr_pkg::result_t            res
);
    import dfr_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic              len_too_big;
    logic [BYTE_W-1:0] xor_with_byte;

    assign len_too_big   = in_byte > cfg.max_payload;
    assign xor_with_byte = xor_reg ^ in_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            bytes_left_reg <= '0;
            xor_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            xor_reg        <= xor_next;
        end
    end

    // Next state
    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        xor_next        = xor_reg;
        if (in_accept)
        begin
            unique case (phase_reg)
                PH_OP:
                begin
                    xor_next   = xor_with_byte;
                    phase_next = PH_TARGET;
                end
                PH_TARGET:
                begin
                    xor_next   = xor_with_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    xor_next = xor_with_byte;
                    if (len_too_big)
                    begin
                        phase_next      = PH_HUNT;
                        bytes_left_next = '0;
                    end
                    else
                    begin
                        bytes_left_next = in_byte;
                        phase_next      = (in_byte != '0) ? PH_PAYLOAD : PH_CHECK;
                    end
                end
                PH_PAYLOAD:
                begin
                    xor_next        = xor_with_byte;
                    bytes_left_next = bytes_left_reg - 1'b1;
                    if (bytes_left_reg == BYTE_W'(1))
                        phase_next = PH_CHECK;
                end
                PH_CHECK:
                begin
                    phase_next      = PH_HUNT;
                    bytes_left_next = '0;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (in_byte == cfg.header_byte)
                    begin
                        xor_next        = in_byte;
                        bytes_left_next = '0;
                        phase_next      = PH_OP;
                    end
                end
            endcase
        end
    end

    // Result for the byte being accepted
    always_comb
    begin
        res.data_byte  = in_byte;
        res.byte_kind  = KIND_HEADER;
        res.frame_end  = 1'b0;
        res.frame_good = 1'b0;
        res_valid      = in_accept;
        unique case (phase_reg)
            PH_OP:      res.byte_kind = KIND_OP;
            PH_TARGET:  res.byte_kind = KIND_TARGET;
            PH_LEN:
            begin
                res.byte_kind = KIND_LEN;
                res.frame_end = len_too_big;
            end
            PH_PAYLOAD: res.byte_kind = KIND_PAYLOAD;
            PH_CHECK:
            begin
                res.byte_kind  = KIND_CHECK;
                res.frame_end  = 1'b1;
                res.frame_good = (in_byte == xor_reg);
            end
            default:
            begin
                // hunting: only the header byte produces a word
                res_valid = in_accept && (in_byte == cfg.header_byte);
            end
        endcase
    end

endmodule

// File: src/dfr_out_buf.sv
// Two-entry output buffer (output register plus skid register) for result words.
module dfr_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dfr_pkg::result_t    push_data,
    output logic                can_push,
    output logic                out_valid,
    input  logic                out_ready,
    output dfr_pkg::result_t    out_data
);
    import dfr_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= push_data;
            else
                out_data_reg <= push_data;
        end
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: src/dfr_checker.sv
// Port-level checks for the deframer, bound to the top level.
module dfr_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic       m_axis_tlast,
    input  logic [3:0] m_axis_tuser
);
    import dfr_pkg::*;

    // good flag only on a checksum word that ends the frame
    a_good_on_check: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |->
            (m_axis_tlast && m_axis_tuser[2:0] == KIND_CHECK))
        else $error("frame_good outside a checksum word");

    // checksum word always ends the frame
    a_check_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2:0] == KIND_CHECK) |-> m_axis_tlast)
        else $error("checksum word without tlast");

    // frame ends only at a checksum or an oversized length
    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tuser[2:0] == KIND_CHECK || m_axis_tuser[2:0] == KIND_LEN))
        else $error("tlast on a word that cannot end a frame");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("stalled output word changed");

endmodule

bind xor_checked_frame_deframer_core dfr_checker u_dfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// File: verif/tb_top.sv
// Self-checking testbench for the XOR-checked frame deframer core.
`timescale 1ns / 100ps

import dfr_pkg::*;

// Tracks the parser state and holds the output words still due.
class frame_tracker;
    logic [BYTE_W-1:0] header_val;
    logic [BYTE_W-1:0] max_len;
    phase_t            parse_at;
    logic [BYTE_W-1:0] left_count;
    logic [BYTE_W-1:0] xor_sum;
    result_t           due_words[$];
    int                errors;

    function new();
        header_val = HEADER_BYTE_RESET;
        max_len    = MAX_PAYLOAD_RESET;
        parse_at   = PH_HUNT;
        left_count = '0;
        xor_sum    = '0;
        errors     = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [BYTE_W-1:0] val);
        case (idx)
            CFG_HEADER_BYTE: header_val = val;
            CFG_MAX_PAYLOAD: max_len    = val;
            default: ;
        endcase
    endfunction

    function void note_rx_byte(logic [BYTE_W-1:0] b);
        result_t w;
        bit      emits;
        emits        = 1'b1;
        w.data_byte  = b;
        w.byte_kind  = KIND_HEADER;
        w.frame_end  = 1'b0;
        w.frame_good = 1'b0;
        case (parse_at)
            PH_OP:
            begin
                xor_sum     = xor_sum ^ b;
                parse_at    = PH_TARGET;
                w.byte_kind = KIND_OP;
            end
            PH_TARGET:
            begin
                xor_sum     = xor_sum ^ b;
                parse_at    = PH_LEN;
                w.byte_kind = KIND_TARGET;
            end
            PH_LEN:
            begin
                xor_sum     = xor_sum ^ b;
                w.byte_kind = KIND_LEN;
                if (b > max_len)
                begin
                    // oversize length aborts the frame right here
                    parse_at    = PH_HUNT;
                    left_count  = '0;
                    w.frame_end = 1'b1;
                end
                else
                begin
                    left_count = b;
                    parse_at   = (b != 0) ? PH_PAYLOAD : PH_CHECK;
                end
            end
            PH_PAYLOAD:
            begin
                xor_sum     = xor_sum ^ b;
                left_count  = left_count - 1'b1;
                if (left_count == 0)
                    parse_at = PH_CHECK;
                w.byte_kind = KIND_PAYLOAD;
            end
            PH_CHECK:
            begin
                w.byte_kind  = KIND_CHECK;
                w.frame_end  = 1'b1;
                w.frame_good = (b == xor_sum);
                parse_at     = PH_HUNT;
                left_count   = '0;
            end
            default:
            begin
                parse_at = PH_HUNT;
                if (b != header_val)
                    emits = 1'b0;
                else
                begin
                    xor_sum    = b;
                    left_count = '0;
                    parse_at   = PH_OP;
                end
            end
        endcase
        if (emits)
            due_words.push_back(w);
    endfunction

    function void check_out_word(result_t got);
        result_t want;
        if (due_words.size() == 0)
        begin
            $display("%0t: word with nothing due: expected none, got byte %02h kind %0d",
                     $time, got.data_byte, got.byte_kind);
            errors++;
            return;
        end
        want = due_words.pop_front();
        if (got.data_byte !== want.data_byte)
        begin
            $display("%0t: data_byte expected %02h got %02h",
                     $time, want.data_byte, got.data_byte);
            errors++;
        end
        if (got.byte_kind !== want.byte_kind)
        begin
            $display("%0t: byte_kind expected %0d got %0d",
                     $time, want.byte_kind, got.byte_kind);
            errors++;
        end
        if (got.frame_end !== want.frame_end)
        begin
            $display("%0t: frame_end expected %0b got %0b",
                     $time, want.frame_end, got.frame_end);
            errors++;
        end
        if (got.frame_good !== want.frame_good)
        begin
            $display("%0t: frame_good expected %0b got %0b",
                     $time, want.frame_good, got.frame_good);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 300;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [7:0]             m_axis_tdata;
    logic                   m_axis_tlast;
    logic [3:0]             m_axis_tuser;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]      cfg_data;

    frame_tracker sb = new();
    int           frame_bytes = 0;
    int           idle_cycles = 0;
    bit           steady = 1'b0;
    bit           hold_rx = 1'b0;

    xor_checked_frame_deframer_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Monitor and watchdog
    always @(posedge clk)
    begin
        result_t got;
        bit      moved;
        moved = 1'b0;
        if (s_axis_tvalid && s_axis_tready)
        begin
            sb.note_rx_byte(s_axis_tdata);
            moved = 1'b1;
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.data_byte  = m_axis_tdata;
            got.byte_kind  = m_axis_tuser[KIND_W-1:0];
            got.frame_good = m_axis_tuser[KIND_W];
            got.frame_end  = m_axis_tlast;
            sb.check_out_word(got);
            moved = 1'b1;
        end
        if (moved)
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, steady stretches, one long hold-off on request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rx)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_rx = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic put_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic put_frame_byte(input logic [7:0] b);
        put_byte(b);
        frame_bytes++;
    endtask

    task automatic send_frame(input logic [7:0] op, input logic [7:0] tgt,
                              input logic [7:0] len, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] p;
        bit         fits;
        fits = (len <= sb.max_len);
        sum  = sb.header_val ^ op ^ tgt ^ len;
        put_frame_byte(sb.header_val);
        put_frame_byte(op);
        put_frame_byte(tgt);
        put_frame_byte(len);
        if (fits)
        begin
            for (int i = 0; i < len; i++)
            begin
                p   = 8'($urandom);
                sum = sum ^ p;
                put_frame_byte(p);
            end
            put_frame_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
        end
    endtask

    task automatic rand_frame();
        int         mx;
        int         r;
        logic [7:0] len;
        mx = int'(sb.max_len);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            // cut-off frame: the next bytes land in the wrong fields
            put_frame_byte(sb.header_val);
            repeat ($urandom_range(0, 2)) put_frame_byte(8'($urandom));
            return;
        end
        if (r < 12 && mx < 255)
            len = 8'($urandom_range(mx + 1, 255));
        else if (r < 18)
            len = (mx > 24) ? 8'($urandom_range(13, 24)) : 8'(mx);
        else
            len = 8'($urandom_range(0, (mx < 12) ? mx : 12));
        send_frame(8'($urandom), 8'($urandom), len, $urandom_range(0, 3) == 0);
    endtask

    // Wait for every due word, then let the parser go quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.due_words.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_settings(input logic [7:0] hdr, input logic [7:0] mx);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HEADER_BYTE;
        cfg_data  <= hdr;
        @(negedge clk);
        cfg_index <= CFG_MAX_PAYLOAD;
        cfg_data  <= mx;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(CFG_HEADER_BYTE, hdr);
        sb.set_reg(CFG_MAX_PAYLOAD, mx);
    endtask

    task automatic run_random(input int upto);
        while (frame_bytes < upto)
            rand_frame();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_HEADER_BYTE;
        cfg_data      = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: dropped noise, good empty frame, bad checksum,
        // oversize length, header value reused as an operation byte.
        put_byte(8'h00);
        put_byte(8'hFF);
        send_frame(8'hFF, 8'h00, 8'd0, 1'b0);
        send_frame(8'h00, 8'hFF, 8'd2, 1'b1);
        send_frame(8'h5A, 8'hA5, 8'd128, 1'b0);
        send_frame(sb.header_val, sb.header_val, 8'd1, 1'b0);
        settle();

        // Smallest header value and payload limit
        load_settings(8'h00, 8'd0);
        send_frame(8'h12, 8'h34, 8'd0, 1'b0);
        send_frame(8'h12, 8'h34, 8'd1, 1'b0);
        send_frame(8'hFF, 8'hFF, 8'd255, 1'b0);
        run_random(300);
        settle();

        // Largest header value and payload limit, one full-length payload
        load_settings(8'hFF, 8'd255);
        send_frame(8'($urandom), 8'($urandom), 8'd255, 1'b0);
        run_random(650);
        settle();

        // Random settings, no idling on either side
        load_settings(8'($urandom), 8'($urandom_range(1, 40)));
        steady = 1'b1;
        send_frame(8'($urandom), 8'($urandom), sb.max_len, 1'b0);
        run_random(1000);
        steady = 1'b0;
        settle();

        // Back to reset values; receiver holds off so the input backs up
        load_settings(HEADER_BYTE_RESET, MAX_PAYLOAD_RESET);
        hold_rx = 1'b1;
        send_frame(8'($urandom), 8'($urandom), 8'd20, 1'b0);
        send_frame(8'($urandom), 8'($urandom), 8'd6, 1'b1);
        run_random(1150);
        // sender pause until the output side has caught up
        s_axis_tvalid <= 1'b0;
        while (sb.due_words.size() != 0)
            @(negedge clk);
        @(negedge clk);
        run_random(1350);
        settle();

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.due_words.size() == 0)
            $display("Verification passed");
        else
        begin
            if (sb.due_words.size() != 0)
                $display("%0t: %0d words still due", $time, sb.due_words.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/dfr_pkg.sv
src/dfr_regs.sv
src/dfr_parser.sv
src/dfr_out_buf.sv
src/xor_checked_frame_deframer_core.sv
src/dfr_checker.sv
verif/tb_top.sv
